FILE: src/pufr_pkg.sv
// ----------------------------------------------------------------------------
// pufr_pkg
// Shared types and constants of the parity union-find table with rollback.
// ----------------------------------------------------------------------------
package pufr_pkg;

    localparam int NODES      = 1024;
    localparam int UNDO_DEPTH = 1024;
    localparam int NW         = $clog2(NODES);
    localparam int SW         = $clog2(2 * NODES);
    localparam int UW         = $clog2(UNDO_DEPTH);
    localparam int CW         = $clog2(UNDO_DEPTH + 1);
    localparam logic [SW-1:0] SIZE_CAP = SW'(2 * NODES - 1);

    typedef enum logic [1:0] {
        CMD_MAKE     = 2'd0,
        CMD_UNION    = 2'd1,
        CMD_QUERY    = 2'd2,
        CMD_ROLLBACK = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]    command;
        logic [NW-1:0] node_a;
        logic [NW-1:0] node_b;
        logic          record;
    } t_in_item;

    typedef struct packed {
        logic [NW-1:0] root;
        logic          parity;
        logic          bipartite;
        logic [1:0]    status;
    } t_out_item;

    typedef struct packed {
        logic [NW-1:0] lower;
        logic [NW-1:0] upper;
        logic [NW-1:0] old_parent;
        logic [SW-1:0] old_size;
        logic          old_flag;
        logic          old_parity;
    } t_undo;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_MAKE,
        S_FIND_RD,
        S_FIND_CHK,
        S_UNI_RD,
        S_UNI_DEC,
        S_UNI_WR,
        S_POP_RD,
        S_POP_WR,
        S_ANS_RD,
        S_ANS_FLAG,
        S_OUT
    } t_state;

    // Datapath operations selected by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MAKE,
        OP_FIND_START_A,
        OP_FIND_START_B,
        OP_FIND_START_ANS,
        OP_FIND_RD,
        OP_FIND_STEP,
        OP_UNI_RD,
        OP_UNI_DEC,
        OP_UNI_WR,
        OP_POP_RD,
        OP_POP_WR,
        OP_FLAG_RD,
        OP_OUT
    } t_op;

    typedef struct packed {
        t_op op;
    } t_ctl;

    typedef struct packed {
        t_cmd command;
        logic find_done;
        logic stack_empty;
        logic push_refused;
    } t_sts;

endpackage

FILE: src/pufr_datapath.sv
// ----------------------------------------------------------------------------
// pufr_datapath
// Node table, undo stack and the registers of one command in flight.
// ----------------------------------------------------------------------------
module pufr_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pufr_pkg::t_in_item   i_item,
    input  pufr_pkg::t_ctl       i_ctl,
    output pufr_pkg::t_sts       o_sts,
    output pufr_pkg::t_out_item  o_item
);

    localparam int NW = pufr_pkg::NW;
    localparam int SW = pufr_pkg::SW;
    localparam int CW = pufr_pkg::CW;
    localparam int UW = pufr_pkg::UW;
    localparam int EW = NW + SW + 2;

    // One node entry: parent, size, parity to parent, bipartite flag.
    logic [EW-1:0] mem_node [pufr_pkg::NODES];
    pufr_pkg::t_undo mem_undo [pufr_pkg::UNDO_DEPTH];

    pufr_pkg::t_in_item r_item;
    logic [NW-1:0] r_x, r_ra, r_rb;
    logic          r_p, r_pa, r_pb;
    logic [NW:0]   r_steps;
    logic [CW-1:0] r_cnt;
    logic [1:0]    r_status;
    logic [EW-1:0] r_rd;
    logic [EW-1:0] r_rd2;
    logic [NW-1:0] r_lo, r_hi;
    logic [SW-1:0] r_size_lo, r_size_hi;
    logic          r_flag_lo, r_flag_hi;
    logic [NW-1:0] r_par_lo;
    logic          r_ptp_lo;
    pufr_pkg::t_undo r_undo;
    pufr_pkg::t_out_item r_out;
    logic          r_restore;

    logic [NW-1:0] rd_parent;
    logic          rd_parity;
    logic          rd_flag;
    logic          find_done;
    logic [SW:0]   sum;

    assign rd_parent = r_rd[EW-1 -: NW];
    assign rd_parity = r_rd[1];
    assign rd_flag   = r_rd[0];
    assign find_done = (rd_parent == r_x) || (r_steps == (NW + 1)'(pufr_pkg::NODES));
    assign sum       = {1'b0, r_size_hi} + {1'b0, r_size_lo};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            unique case (i_ctl.op)
                pufr_pkg::OP_LOAD: begin
                    r_item   <= i_item;
                    r_status <= pufr_pkg::ST_OK;
                end
                pufr_pkg::OP_MAKE: begin
                    mem_node[r_item.node_a] <= {r_item.node_a, SW'(1), 1'b0, 1'b1};
                end
                pufr_pkg::OP_FIND_START_A: begin
                    r_x <= r_item.node_a; r_p <= 1'b0; r_steps <= '0;
                end
                pufr_pkg::OP_FIND_START_B: begin
                    r_ra <= r_x; r_pa <= r_p;
                    r_x <= r_item.node_b; r_p <= 1'b0; r_steps <= '0;
                end
                pufr_pkg::OP_FIND_START_ANS: begin
                    r_x <= r_item.node_a; r_p <= 1'b0; r_steps <= '0;
                end
                pufr_pkg::OP_FIND_RD: begin
                    r_rd <= mem_node[r_x];
                end
                pufr_pkg::OP_FIND_STEP: begin
                    if (!find_done) begin
                        r_p     <= r_p ^ rd_parity;
                        r_x     <= rd_parent;
                        r_steps <= r_steps + 1'b1;
                    end
                end
                pufr_pkg::OP_UNI_RD: begin
                    // Root entries of both sets; r_x holds the root of node_b.
                    r_rb  <= r_x;
                    r_pb  <= r_p;
                    r_rd  <= mem_node[r_ra];
                    r_rd2 <= mem_node[r_x];
                end
                pufr_pkg::OP_UNI_DEC: begin
                    // r_rd is the root of node_a, r_rd2 the root of node_b.
                    if (r_rd[EW-NW-1 -: SW] > r_rd2[EW-NW-1 -: SW]) begin
                        r_lo <= r_rb; r_hi <= r_ra;
                        r_size_lo <= r_rd2[EW-NW-1 -: SW]; r_size_hi <= r_rd[EW-NW-1 -: SW];
                        r_flag_lo <= r_rd2[0]; r_flag_hi <= r_rd[0];
                        r_par_lo  <= r_rd2[EW-1 -: NW]; r_ptp_lo <= r_rd2[1];
                        r_undo.old_parent <= r_rd2[EW-1 -: NW];
                    end else begin
                        r_lo <= r_ra; r_hi <= r_rb;
                        r_size_lo <= r_rd[EW-NW-1 -: SW]; r_size_hi <= r_rd2[EW-NW-1 -: SW];
                        r_flag_lo <= r_rd[0]; r_flag_hi <= r_rd2[0];
                        r_par_lo  <= r_rd[EW-1 -: NW]; r_ptp_lo <= r_rd[1];
                    end
                    if (r_item.record && r_cnt == CW'(pufr_pkg::UNDO_DEPTH))
                        r_status <= pufr_pkg::ST_FULL;
                end
                pufr_pkg::OP_UNI_WR: begin
                    if (r_status == pufr_pkg::ST_OK) begin
                        if (r_ra == r_rb) begin
                            if (r_item.record) begin
                                mem_undo[r_cnt[UW-1:0]] <= {r_ra, r_ra, r_par_lo,
                                    r_size_lo, r_flag_lo, r_ptp_lo};
                                r_cnt <= r_cnt + 1'b1;
                            end
                            mem_node[r_ra] <= {r_par_lo, r_size_lo, r_ptp_lo,
                                r_flag_lo & (r_pa ^ r_pb)};
                        end else begin
                            if (r_item.record) begin
                                mem_undo[r_cnt[UW-1:0]] <= {r_lo, r_hi, r_par_lo,
                                    r_size_hi, r_flag_hi, r_ptp_lo};
                                r_cnt <= r_cnt + 1'b1;
                            end
                            mem_node[r_lo] <= {r_hi, r_size_lo, r_pa ^ r_pb ^ 1'b1, r_flag_lo};
                            mem_node[r_hi] <= {r_hi,
                                (sum > {1'b0, pufr_pkg::SIZE_CAP}) ? pufr_pkg::SIZE_CAP
                                                                   : sum[SW-1:0],
                                1'b0, r_flag_hi & r_flag_lo};
                        end
                    end
                end
                pufr_pkg::OP_POP_RD: begin
                    if (r_cnt == '0) begin
                        r_status <= pufr_pkg::ST_EMPTY;
                    end else begin
                        r_undo <= mem_undo[r_cnt[UW-1:0] - 1'b1];
                        r_cnt  <= r_cnt - 1'b1;
                    end
                end
                pufr_pkg::OP_POP_WR: begin
                    if (r_status == pufr_pkg::ST_OK) begin
                        r_rd  <= mem_node[r_undo.lower];
                        r_rd2 <= mem_node[r_undo.upper];
                    end
                end
                pufr_pkg::OP_FLAG_RD: begin
                    r_rd <= mem_node[r_x];
                end
                pufr_pkg::OP_OUT: begin
                    r_out <= {r_x, r_p, rd_flag, r_status};
                end
                default: begin
                end
            endcase

            // The undo restore needs the current lower and upper entries first;
            // a second pass writes them back once the reads have landed. The
            // controller issues no operation in that cycle.
            if (r_restore) begin
                if (r_undo.lower == r_undo.upper) begin
                    mem_node[r_undo.lower] <= {r_undo.old_parent, r_undo.old_size,
                        r_undo.old_parity, r_undo.old_flag};
                end else begin
                    mem_node[r_undo.lower] <= {r_undo.old_parent, r_rd[EW-NW-1 -: SW],
                        r_undo.old_parity, r_rd[0]};
                    mem_node[r_undo.upper] <= {r_rd2[EW-1 -: NW], r_undo.old_size,
                        r_rd2[1], r_undo.old_flag};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_restore <= 1'b0;
        end else begin
            r_restore <= (i_ctl.op == pufr_pkg::OP_POP_WR) && (r_status == pufr_pkg::ST_OK);
        end
    end

    assign o_sts.command      = pufr_pkg::t_cmd'(r_item.command);
    assign o_sts.find_done    = find_done;
    assign o_sts.stack_empty  = (r_cnt == '0);
    assign o_sts.push_refused = (r_status == pufr_pkg::ST_FULL);
    assign o_item             = r_out;

endmodule

FILE: src/pufr_ctrl.sv
// ----------------------------------------------------------------------------
// pufr_ctrl
// Command sequencer: one item at a time through finds, writes and the answer.
// ----------------------------------------------------------------------------
module pufr_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    input  pufr_pkg::t_sts  i_sts,
    output pufr_pkg::t_ctl  o_ctl
);

    pufr_pkg::t_state r_state, n_state;
    logic r_phase, n_phase;   // 0: finds of a union, 1: final answer find
    logic r_second, n_second; // second find of a union
    logic r_valid, n_valid;
    logic r_pop_wait, n_pop_wait;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pufr_pkg::S_IDLE;
            r_phase <= 1'b0; r_second <= 1'b0; r_valid <= 1'b0; r_pop_wait <= 1'b0;
        end else begin
            r_state <= n_state; r_phase <= n_phase; r_second <= n_second;
            r_valid <= n_valid; r_pop_wait <= n_pop_wait;
        end
    end

    always_comb begin
        n_state = r_state; n_phase = r_phase; n_second = r_second;
        n_pop_wait = 1'b0;
        n_valid = r_valid && i_out_stall;
        o_ctl.op = pufr_pkg::OP_NONE;
        o_in_stall = 1'b1;
        unique case (r_state)
            pufr_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_ctl.op = pufr_pkg::OP_LOAD;
                    n_state = pufr_pkg::S_MAKE;
                end
            end
            pufr_pkg::S_MAKE: begin
                unique case (i_sts.command)
                    pufr_pkg::CMD_MAKE: begin
                        o_ctl.op = pufr_pkg::OP_MAKE; n_state = pufr_pkg::S_ANS_RD;
                    end
                    pufr_pkg::CMD_UNION: begin
                        o_ctl.op = pufr_pkg::OP_FIND_START_A;
                        n_phase = 1'b0; n_second = 1'b0; n_state = pufr_pkg::S_FIND_RD;
                    end
                    pufr_pkg::CMD_QUERY: n_state = pufr_pkg::S_ANS_RD;
                    default: n_state = pufr_pkg::S_POP_RD;
                endcase
            end
            pufr_pkg::S_FIND_RD: begin
                o_ctl.op = pufr_pkg::OP_FIND_RD; n_state = pufr_pkg::S_FIND_CHK;
            end
            pufr_pkg::S_FIND_CHK: begin
                o_ctl.op = pufr_pkg::OP_FIND_STEP;
                if (!i_sts.find_done) n_state = pufr_pkg::S_FIND_RD;
                else if (r_phase) n_state = pufr_pkg::S_ANS_FLAG;
                else if (!r_second) n_state = pufr_pkg::S_UNI_RD;
                else n_state = pufr_pkg::S_UNI_DEC;
            end
            pufr_pkg::S_UNI_RD: begin
                if (!r_second) begin
                    o_ctl.op = pufr_pkg::OP_FIND_START_B;
                    n_second = 1'b1; n_state = pufr_pkg::S_FIND_RD;
                end else begin
                    o_ctl.op = pufr_pkg::OP_UNI_RD; n_state = pufr_pkg::S_UNI_WR;
                end
            end
            pufr_pkg::S_UNI_DEC: begin
                o_ctl.op = pufr_pkg::OP_UNI_RD; n_state = pufr_pkg::S_UNI_WR;
                n_second = 1'b0;
            end
            pufr_pkg::S_UNI_WR: begin
                if (!r_second) begin
                    o_ctl.op = pufr_pkg::OP_UNI_DEC; n_second = 1'b1;
                end else begin
                    o_ctl.op = pufr_pkg::OP_UNI_WR; n_state = pufr_pkg::S_ANS_RD;
                end
            end
            pufr_pkg::S_POP_RD: begin
                o_ctl.op = pufr_pkg::OP_POP_RD; n_state = pufr_pkg::S_POP_WR;
            end
            pufr_pkg::S_POP_WR: begin
                if (!r_pop_wait) begin
                    o_ctl.op = pufr_pkg::OP_POP_WR; n_pop_wait = 1'b1;
                end else begin
                    n_state = pufr_pkg::S_ANS_RD;
                end
            end
            pufr_pkg::S_ANS_RD: begin
                o_ctl.op = pufr_pkg::OP_FIND_START_ANS;
                n_phase = 1'b1; n_state = pufr_pkg::S_FIND_RD;
            end
            pufr_pkg::S_ANS_FLAG: begin
                o_ctl.op = pufr_pkg::OP_FLAG_RD; n_state = pufr_pkg::S_OUT;
            end
            pufr_pkg::S_OUT: begin
                if (!r_valid) begin
                    o_ctl.op = pufr_pkg::OP_OUT;
                    n_valid = 1'b1; n_state = pufr_pkg::S_IDLE;
                end
            end
            default: n_state = pufr_pkg::S_IDLE;
        endcase
    end

    assign o_out_valid = r_valid;

endmodule

FILE: src/parity_union_find_rollback.sv
// ----------------------------------------------------------------------------
// parity_union_find_rollback
// Disjoint-set table with parity bits, bipartite flags and an undo stack.
// ----------------------------------------------------------------------------
// Each link of a find costs one node-table read and one check. Throughput: one
// item at a time; the next item is taken while a finished result waits to be
// taken. Reset clears the controller and the undo count; the node table and the
// undo stack are not cleared.
module parity_union_find_rollback (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  pufr_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output pufr_pkg::t_out_item  o_out_data
);

    // Command and status between the sequencer and the datapath.
    pufr_pkg::t_ctl ctl;
    pufr_pkg::t_sts sts;

    pufr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_ctl       (ctl)
    );

    // The datapath holds the item, the node table and the undo stack.
    pufr_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_in_data),
        .i_ctl   (ctl),
        .o_sts   (sts),
        .o_item  (o_out_data)
    );

    // A refused push is reported with the full-stack status.
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctl.op == pufr_pkg::OP_OUT) && sts.push_refused
            |=> o_out_data.status == pufr_pkg::ST_FULL)
        else $error("full-stack refusal lost its status");

    // The result appears only once the sequencer left its output state.
    a_out_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !o_in_stall)
        else $error("result raised outside idle");

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the parity union-find table with rollback. A
// behavioral copy of the table predicts root, parity, flag and status for
// every command; results are compared in order against that prediction while
// both sides of the block idle at random.
// ----------------------------------------------------------------------------
module tb_top;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    pufr_pkg::t_in_item  i_in_data;
    logic                o_out_valid;
    logic                i_out_stall;
    pufr_pkg::t_out_item o_out_data;

    parity_union_find_rollback i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    // Shadow copy of the node table and the undo stack.
    logic [pufr_pkg::NW-1:0] tbl_parent [pufr_pkg::NODES];
    logic [pufr_pkg::SW-1:0] tbl_size   [pufr_pkg::NODES];
    logic                    tbl_par    [pufr_pkg::NODES];
    logic                    tbl_flag   [pufr_pkg::NODES];
    pufr_pkg::t_undo         undo_mem   [pufr_pkg::UNDO_DEPTH];
    int                      undo_cnt;

    // Nodes that have seen make_set; only these are ever addressed.
    logic                    node_live  [pufr_pkg::NODES];
    logic [pufr_pkg::NW-1:0] live_list  [$];

    pufr_pkg::t_out_item     pending_results [$];
    int                      errors;
    int                      results_seen;
    int                      send_idle_pct;
    int                      recv_idle_pct;

    initial begin
        i_clk = 1'b0;
    end

    always #10 i_clk = ~i_clk;

    // The run must never take this long, even with every path at full length.
    initial begin
        #200ms;
        $display("Some tests failed");
        $finish;
    end

    // Follow parent links to the root, collecting the parity of the path.
    function automatic logic [pufr_pkg::NW-1:0] walk_to_root(
        input logic [pufr_pkg::NW-1:0] v, output logic par);
        logic [pufr_pkg::NW-1:0] x;
        int                      steps;
        x = v;
        par = 1'b0;
        steps = 0;
        while (tbl_parent[x] != x && steps < pufr_pkg::NODES) begin
            par = par ^ tbl_par[x];
            x = tbl_parent[x];
            steps++;
        end
        return x;
    endfunction

    // Apply one command to the shadow table and return its expected result.
    function automatic pufr_pkg::t_out_item apply_command(input pufr_pkg::t_in_item it);
        pufr_pkg::t_out_item     res;
        logic [pufr_pkg::NW-1:0] ra, rb, lo, hi, r;
        logic                    pa, pb, p;
        logic [pufr_pkg::SW:0]   sum;
        pufr_pkg::t_undo         u;
        res.status = pufr_pkg::ST_OK;
        case (pufr_pkg::t_cmd'(it.command))
            pufr_pkg::CMD_MAKE: begin
                tbl_parent[it.node_a] = it.node_a;
                tbl_size[it.node_a] = pufr_pkg::SW'(1);
                tbl_par[it.node_a] = 1'b0;
                tbl_flag[it.node_a] = 1'b1;
            end
            pufr_pkg::CMD_UNION: begin
                ra = walk_to_root(it.node_a, pa);
                rb = walk_to_root(it.node_b, pb);
                if (it.record && undo_cnt >= pufr_pkg::UNDO_DEPTH) begin
                    res.status = pufr_pkg::ST_FULL;
                end else if (ra == rb) begin
                    if (it.record) begin
                        u = '{ra, ra, tbl_parent[ra], tbl_size[ra], tbl_flag[ra], tbl_par[ra]};
                        undo_mem[undo_cnt++] = u;
                    end
                    if (pa == pb) tbl_flag[ra] = 1'b0;
                end else begin
                    lo = ra;
                    hi = rb;
                    if (tbl_size[ra] > tbl_size[rb]) begin
                        lo = rb;
                        hi = ra;
                    end
                    if (it.record) begin
                        u = '{lo, hi, tbl_parent[lo], tbl_size[hi], tbl_flag[hi], tbl_par[lo]};
                        undo_mem[undo_cnt++] = u;
                    end
                    tbl_parent[lo] = hi;
                    sum = tbl_size[hi] + tbl_size[lo];
                    tbl_size[hi] = (sum > pufr_pkg::SIZE_CAP) ? pufr_pkg::SIZE_CAP
                                                              : sum[pufr_pkg::SW-1:0];
                    tbl_flag[hi] = tbl_flag[hi] & tbl_flag[lo];
                    tbl_par[lo] = pa ^ pb ^ 1'b1;
                end
            end
            pufr_pkg::CMD_ROLLBACK: begin
                if (undo_cnt == 0) begin
                    res.status = pufr_pkg::ST_EMPTY;
                end else begin
                    u = undo_mem[--undo_cnt];
                    tbl_parent[u.lower] = u.old_parent;
                    tbl_size[u.upper] = u.old_size;
                    tbl_flag[u.upper] = u.old_flag;
                    tbl_par[u.lower] = u.old_parity;
                end
            end
            default: ;
        endcase
        r = walk_to_root(it.node_a, p);
        res.root = r;
        res.parity = p;
        res.bipartite = tbl_flag[r];
        return res;
    endfunction

    // Drive one item, predict its result and wait until it is taken. Valid
    // stays up after the accepting edge until the next item or an idle cycle.
    task automatic send_item(input pufr_pkg::t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        if (pufr_pkg::t_cmd'(it.command) == pufr_pkg::CMD_MAKE && !node_live[it.node_a]) begin
            node_live[it.node_a] = 1'b1;
            live_list.insert(live_list.size(), it.node_a);
        end
        pending_results.insert(pending_results.size(), apply_command(it));
        i_in_valid <= 1'b1;
        i_in_data <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [pufr_pkg::NW-1:0] pick_live();
        return live_list[$urandom_range(live_list.size() - 1)];
    endfunction

    task automatic send_cmd(input pufr_pkg::t_cmd c, input logic [pufr_pkg::NW-1:0] a,
                            input logic [pufr_pkg::NW-1:0] b, input logic rec);
        pufr_pkg::t_in_item it;
        it.command = c;
        it.node_a = a;
        it.node_b = b;
        it.record = rec;
        send_item(it);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    // Receiver: random stalls, and every taken result checked in order.
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge i_clk) begin
        pufr_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: result expected none actual %h", $time, o_out_data);
            end else begin
                want = pending_results.pop_front();
                if (o_out_data.root !== want.root) begin
                    errors++;
                    $display("%0t: root expected %0d actual %0d",
                             $time, want.root, o_out_data.root);
                end
                if (o_out_data.parity !== want.parity) begin
                    errors++;
                    $display("%0t: parity expected %0d actual %0d",
                             $time, want.parity, o_out_data.parity);
                end
                if (o_out_data.bipartite !== want.bipartite) begin
                    errors++;
                    $display("%0t: bipartite expected %0d actual %0d",
                             $time, want.bipartite, o_out_data.bipartite);
                end
                if (o_out_data.status !== want.status) begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, o_out_data.status);
                end
            end
        end
    end

    // Directed: extreme node indexes, every command, odd cycles, the empty
    // stack refusal and a union of a node with itself.
    task automatic test_directed();
        send_cmd(pufr_pkg::CMD_MAKE, '0, '0, 1'b0);
        send_cmd(pufr_pkg::CMD_ROLLBACK, '0, '0, 1'b0);
        send_cmd(pufr_pkg::CMD_MAKE, '1, '0, 1'b0);
        send_cmd(pufr_pkg::CMD_MAKE, 10'h155, '1, 1'b1);
        send_cmd(pufr_pkg::CMD_MAKE, 10'h2AA, '0, 1'b0);
        send_cmd(pufr_pkg::CMD_UNION, '0, '1, 1'b1);
        send_cmd(pufr_pkg::CMD_QUERY, '1, '0, 1'b0);
        send_cmd(pufr_pkg::CMD_UNION, 10'h155, 10'h2AA, 1'b1);
        send_cmd(pufr_pkg::CMD_UNION, 10'h2AA, '0, 1'b1);
        send_cmd(pufr_pkg::CMD_QUERY, 10'h155, 10'h2AA, 1'b0);
        send_cmd(pufr_pkg::CMD_UNION, 10'h155, '1, 1'b1);
        send_cmd(pufr_pkg::CMD_UNION, '1, '1, 1'b0);
        send_cmd(pufr_pkg::CMD_QUERY, '0, '0, 1'b0);
        send_cmd(pufr_pkg::CMD_ROLLBACK, 10'h155, '0, 1'b0);
        send_cmd(pufr_pkg::CMD_ROLLBACK, '1, '0, 1'b0);
        send_cmd(pufr_pkg::CMD_QUERY, 10'h2AA, '0, 1'b0);
        send_cmd(pufr_pkg::CMD_ROLLBACK, '0, '0, 1'b0);
        send_cmd(pufr_pkg::CMD_ROLLBACK, '0, '0, 1'b0);
        send_cmd(pufr_pkg::CMD_ROLLBACK, '0, '0, 1'b0);
        send_cmd(pufr_pkg::CMD_QUERY, 10'h155, '0, 1'b0);
        send_cmd(pufr_pkg::CMD_MAKE, 10'h155, '0, 1'b0);
    endtask

    // Random graph building with rollbacks; recording is mostly on.
    task automatic test_random(input int count, input int cluster);
        int                      k, sel;
        logic [pufr_pkg::NW-1:0] a, b;
        for (k = 0; k < count; k++) begin
            sel = $urandom_range(99);
            a = (live_list.size() == 0) ? pufr_pkg::NW'($urandom) : pick_live();
            b = (live_list.size() == 0) ? a : pick_live();
            if (live_list.size() == 0 || sel < 15) begin
                a = pufr_pkg::NW'($urandom_range(cluster - 1));
                if ($urandom_range(3) == 0) a = pufr_pkg::NW'($urandom);
                send_cmd(pufr_pkg::CMD_MAKE, a, pufr_pkg::NW'($urandom), 1'($urandom));
            end else if (sel < 65) begin
                send_cmd(pufr_pkg::CMD_UNION, a, b, $urandom_range(9) != 0);
            end else if (sel < 82) begin
                send_cmd(pufr_pkg::CMD_QUERY, a, pufr_pkg::NW'($urandom), 1'($urandom));
            end else begin
                send_cmd(pufr_pkg::CMD_ROLLBACK, a, pufr_pkg::NW'($urandom), 1'($urandom));
            end
        end
    endtask

    // Fill the undo stack to its limit, hit the full refusal, then unwind.
    task automatic test_stack_full();
        int k;
        while (undo_cnt < pufr_pkg::UNDO_DEPTH) send_cmd(pufr_pkg::CMD_UNION, '0, '0, 1'b1);
        send_cmd(pufr_pkg::CMD_UNION, '0, 10'h155, 1'b1);
        send_cmd(pufr_pkg::CMD_UNION, '1, 10'h2AA, 1'b0);
        send_cmd(pufr_pkg::CMD_QUERY, '1, '0, 1'b0);
        for (k = 0; k < 8; k++) send_cmd(pufr_pkg::CMD_ROLLBACK, '1, '0, 1'b0);
    endtask

    // The sender holds off until the block has answered everything.
    task automatic test_drain_pause();
        wait_drained();
        send_cmd(pufr_pkg::CMD_QUERY, pick_live(), '0, 1'b0);
    endtask

    initial begin
        int k;
        errors = 0;
        results_seen = 0;
        undo_cnt = 0;
        for (k = 0; k < pufr_pkg::NODES; k++) begin
            node_live[k] = 1'b0;
            tbl_parent[k] = '0;
            tbl_size[k] = '0;
            tbl_par[k] = 1'b0;
            tbl_flag[k] = 1'b0;
        end
        send_idle_pct = 22;
        recv_idle_pct = 86;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_stall = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random(200, 16);
        test_drain_pause();
        send_idle_pct = 86;
        recv_idle_pct = 22;
        test_random(250, 64);
        test_stack_full();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(120, 1024);
        test_random(40, 8);

        wait_drained();
        repeat (200) @(posedge i_clk);
        $display("Checked %0d results: make_set, union with and without undo,", results_seen);
        $display("query, rollback, empty and full undo stack under random stalls.");
        if (errors == 0 && pending_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
